/* sv/button_edge_autorepeat_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the button edge and auto-repeat block.
// Each macro expects signals named clk and rst in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef BUTTON_EDGE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_EDGE_AUTOREPEAT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BEA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_edge_autorepeat: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BEA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_edge_autorepeat: next-cycle check failed");

`endif

/* sv/bea_pkg.sv */
// ---------------------------------------------------------------------------
// bea_pkg
// Shared widths, defaults, register codes and types of the button block.
// ---------------------------------------------------------------------------
package bea_pkg;

  localparam int PIN_W      = 5;
  localparam int TIME_W     = 64;
  localparam int CFG_W      = 32;
  localparam int ADDR_W     = 3;
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 24;
  localparam int BUTTON_COUNT_DEF = 5;

  localparam logic [CFG_W-1:0] DEFAULT_DELAY_US = CFG_W'(1000 * 80);

  typedef enum logic [0:0] {
    REG_INITIAL_DELAY = 1'b0,
    REG_REPEAT_PERIOD = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] initial_delay_us;
    logic [CFG_W-1:0] repeat_period_us;
  } cfg_t;

  // Per-button results of one frame.
  typedef struct packed {
    logic repeat_hit;
    logic held;
    logic released;
    logic pressed;
  } lane_flags_t;

  // Result item, pressed_mask in the lowest bits.
  typedef struct packed {
    logic [PIN_W-1:0] repeat_mask;
    logic [PIN_W-1:0] held_mask;
    logic [PIN_W-1:0] released_mask;
    logic [PIN_W-1:0] pressed_mask;
  } result_t;

endpackage

/* sv/bea_cfg.sv */
// ---------------------------------------------------------------------------
// bea_cfg
// APB register file holding the initial delay and the repeat period.
// ---------------------------------------------------------------------------
module bea_cfg
  import bea_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_delay_us <= DEFAULT_DELAY_US;
      cfg.repeat_period_us <= DEFAULT_DELAY_US;
    end else if (wr_en) begin
      case (reg_idx)
        REG_INITIAL_DELAY: cfg.initial_delay_us <= pwdata;
        REG_REPEAT_PERIOD: cfg.repeat_period_us <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INITIAL_DELAY: prdata = cfg.initial_delay_us;
      REG_REPEAT_PERIOD: prdata = cfg.repeat_period_us;
      default:           prdata = '0;
    endcase
  end

endmodule

/* sv/bea_lane.sv */
// ---------------------------------------------------------------------------
// bea_lane
// Edge detection and auto-repeat timing for a single button.
// ---------------------------------------------------------------------------
module bea_lane
  import bea_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              down,
  input  logic [TIME_W-1:0] now_us,
  input  logic [TIME_W-1:0] press_ref,
  input  logic [CFG_W-1:0]  repeat_period_us,
  output lane_flags_t       flags
);

  logic              was_held;
  logic [TIME_W-1:0] ref_time;
  logic [TIME_W-1:0] ref_time_next;
  logic [TIME_W-1:0] diff;
  logic              repeat_hit;

  // The difference is read as two's complement; a negative one never fires.
  assign diff       = now_us - ref_time;
  assign repeat_hit = down && was_held && !diff[TIME_W-1]
                      && (diff > {{(TIME_W-CFG_W){1'b0}}, repeat_period_us});

  always_comb begin
    if (!down) begin
      ref_time_next = '0;
    end else if (!was_held) begin
      ref_time_next = press_ref;
    end else if (repeat_hit) begin
      ref_time_next = now_us;
    end else begin
      ref_time_next = ref_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_held <= 1'b0;
      ref_time <= '0;
    end else if (fire) begin
      was_held <= down;
      ref_time <= ref_time_next;
    end
  end

  assign flags.pressed    = down && !was_held;
  assign flags.released   = !down && was_held;
  assign flags.held       = down;
  assign flags.repeat_hit = repeat_hit;

endmodule

/* sv/button_edge_autorepeat.sv */
// ---------------------------------------------------------------------------
// button_edge_autorepeat
// Per-button press, release, held and auto-repeat flags from scan frames.
// ---------------------------------------------------------------------------
// Each frame carries active-low button levels and the microsecond time. It
// is captured in an input register together with now plus the initial
// delay, then all buttons are evaluated in parallel into an output
// register. The block takes one frame per clock cycle while the output is
// not stalled; the single 64-bit subtract and compare per button sets the
// clock period. Buttons beyond the five pin levels carry no results and
// are not built.
`include "button_edge_autorepeat_assert.svh"

module button_edge_autorepeat
  import bea_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // pin_levels[4:0], now_us[68:5], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // pressed, released, held, repeat masks
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [CFG_W-1:0]     pwdata,
  output logic [CFG_W-1:0]     prdata,
  output logic                 pready
);

  localparam int LANES = (BUTTON_COUNT < PIN_W) ? BUTTON_COUNT : PIN_W;

  cfg_t              cfg;
  logic              in_valid;
  logic [PIN_W-1:0]  in_levels;
  logic [TIME_W-1:0] in_now;
  logic [TIME_W-1:0] in_press_ref;
  logic              s_fire;
  logic              fire;
  lane_flags_t       flags [PIN_W];
  result_t           res;
  result_t           out_res;

  bea_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_levels    <= s_tdata[PIN_W-1:0];
      in_now       <= s_tdata[PIN_W+TIME_W-1:PIN_W];
      in_press_ref <= s_tdata[PIN_W+TIME_W-1:PIN_W]
                      + {{(TIME_W-CFG_W){1'b0}}, cfg.initial_delay_us};
    end
  end

  for (genvar i = 0; i < PIN_W; i++) begin : g_lane
    if (i < LANES) begin : g_on
      bea_lane u_lane (
        .clk              (clk),
        .rst              (rst),
        .fire             (fire),
        .down             (!in_levels[i]),
        .now_us           (in_now),
        .press_ref        (in_press_ref),
        .repeat_period_us (cfg.repeat_period_us),
        .flags            (flags[i])
      );
    end else begin : g_off
      assign flags[i] = '0;
    end
    assign res.pressed_mask[i]  = flags[i].pressed;
    assign res.released_mask[i] = flags[i].released;
    assign res.held_mask[i]     = flags[i].held;
    assign res.repeat_mask[i]   = flags[i].repeat_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_res};

  `BEA_ASSERT_NEXT(a_fire_gives_result, fire, m_tvalid)
  `BEA_ASSERT_NOW(a_edges_follow_held, m_tvalid,
    ((out_res.pressed_mask & ~out_res.held_mask) == '0)
    && ((out_res.released_mask & out_res.held_mask) == '0))
  `BEA_ASSERT_NOW(a_repeat_only_while_held, m_tvalid,
    ((out_res.repeat_mask & ~out_res.held_mask) == '0)
    && ((out_res.repeat_mask & out_res.pressed_mask) == '0))

endmodule
